>>> src/csrc_pkg.sv
// ----------------------------------------------------------------------------
// csrc_pkg
// Shared sizes, status codes and controller/datapath bundles for the
// call site receiver cache.
// ----------------------------------------------------------------------------
package csrc_pkg;

  localparam int NUM_SITES      = 16;
  localparam int SLOTS_PER_SITE = 4;
  localparam int TOTAL_SLOTS    = NUM_SITES * SLOTS_PER_SITE;

  localparam int PC_W     = 32;
  localparam int CLASS_W  = 32;
  localparam int COUNT_W  = 32;
  localparam int STATUS_W = 3;
  localparam int SLOTO_W  = 3;

  localparam int SITE_W = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1;
  localparam int LD_W   = $clog2(NUM_SITES + 1);
  localparam int SLOT_W = (SLOTS_PER_SITE > 1) ? $clog2(SLOTS_PER_SITE) : 1;
  localparam int ADDR_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED     = 3'd0,
    ST_HIT        = 3'd1,
    ST_INSERTED   = 3'd2,
    ST_MEGA       = 3'd3,
    ST_MISSING    = 3'd4,
    ST_TABLE_FULL = 3'd5,
    ST_ZERO_CLASS = 3'd6
  } status_t;

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [COUNT_W-1:0] cnt;
  } slot_entry_t;

  typedef struct packed {
    logic    capture;   // latch input item
    logic    pc_wr;     // append site pc
    logic    clr_wr;    // clear one slot of the new site
    logic    ld_inc;    // site appended
    logic    site_clr;
    logic    site_inc;
    logic    slot_clr;
    logic    slot_inc;
    logic    rd_en;     // read slot entry
    logic    upd_wr;    // write hit or insert
    logic    res_load;  // move result to output register
    status_t res_status;
  } csrc_cmd_t;

  typedef struct packed {
    logic in_load;      // incoming item is a load
    logic in_cls_zero;
    logic table_full;
    logic site_end;
    logic site_match;
    logic slot_last;
    logic slot_hit;
    logic slot_empty;
    logic out_free;
  } csrc_sts_t;

endpackage

>>> src/csrc_if.sv
// ----------------------------------------------------------------------------
// csrc channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface csrc_in_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [csrc_pkg::PC_W-1:0]    site_pc;
  logic [csrc_pkg::CLASS_W-1:0] class_id;

  modport source (output valid, kind, site_pc, class_id, input ready);
  modport sink   (input valid, kind, site_pc, class_id, output ready);
endinterface

interface csrc_out_if;
  logic                          valid;
  logic                          ready;
  logic [csrc_pkg::STATUS_W-1:0] status;
  logic [csrc_pkg::SLOTO_W-1:0]  slot;
  logic [csrc_pkg::COUNT_W-1:0]  count;

  modport source (output valid, status, slot, count, input ready);
  modport sink   (input valid, status, slot, count, output ready);
endinterface

>>> src/csrc_ctrl.sv
// ----------------------------------------------------------------------------
// csrc_ctrl
// Sequencer: site append with slot clear sweep, site search, slot scan.
// ----------------------------------------------------------------------------
module csrc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  csrc_pkg::csrc_sts_t sts,
  output csrc_pkg::csrc_cmd_t cmd
);
  import csrc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_SRCH,
    S_RD,
    S_CHK,
    S_RESP
  } state_t;

  state_t  state_r, state_nxt;
  status_t res_status_r, res_status_nxt;

  always_comb begin
    cmd            = '0;
    cmd.res_status = res_status_r;
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture  = 1'b1;
          cmd.slot_clr = 1'b1;
          cmd.site_clr = 1'b1;
          if (sts.in_load) begin
            if (sts.table_full) begin
              res_status_nxt = ST_TABLE_FULL;
              state_nxt      = S_RESP;
            end else begin
              cmd.pc_wr = 1'b1;
              state_nxt = S_CLR;
            end
          end else if (sts.in_cls_zero) begin
            res_status_nxt = ST_ZERO_CLASS;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_SRCH;
          end
        end
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.slot_last) begin
          cmd.ld_inc     = 1'b1;
          res_status_nxt = ST_LOADED;
          state_nxt      = S_RESP;
        end else begin
          cmd.slot_inc = 1'b1;
        end
      end
      S_SRCH: begin
        priority if (sts.site_end) begin
          res_status_nxt = ST_MISSING;
          state_nxt      = S_RESP;
        end else if (sts.site_match) begin
          state_nxt = S_RD;
        end else begin
          cmd.site_inc = 1'b1;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        priority if (sts.slot_hit) begin
          cmd.upd_wr     = 1'b1;
          res_status_nxt = ST_HIT;
          state_nxt      = S_RESP;
        end else if (sts.slot_empty) begin
          cmd.upd_wr     = 1'b1;
          res_status_nxt = ST_INSERTED;
          state_nxt      = S_RESP;
        end else if (sts.slot_last) begin
          res_status_nxt = ST_MEGA;
          state_nxt      = S_RESP;
        end else begin
          cmd.slot_inc = 1'b1;
          state_nxt    = S_RD;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      res_status_r <= ST_LOADED;
    end else begin
      state_r      <= state_nxt;
      res_status_r <= res_status_nxt;
    end
  end

endmodule

>>> src/csrc_dp.sv
// ----------------------------------------------------------------------------
// csrc_dp
// Site pc registers, slot memory, counters and the result register.
// ----------------------------------------------------------------------------
module csrc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_kind,
  input  logic [csrc_pkg::PC_W-1:0]     in_site_pc,
  input  logic [csrc_pkg::CLASS_W-1:0]  in_class_id,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [csrc_pkg::STATUS_W-1:0] out_status,
  output logic [csrc_pkg::SLOTO_W-1:0]  out_slot,
  output logic [csrc_pkg::COUNT_W-1:0]  out_count,
  input  csrc_pkg::csrc_cmd_t           cmd,
  output csrc_pkg::csrc_sts_t           sts
);
  import csrc_pkg::*;

  logic [PC_W-1:0]    pcs_r [NUM_SITES];
  slot_entry_t        mem   [TOTAL_SLOTS];

  logic [PC_W-1:0]     pc_r;
  logic [CLASS_W-1:0]  cls_r;
  logic [LD_W-1:0]     ld_r;
  logic [LD_W-1:0]     idx_r;
  logic [SLOT_W-1:0]   slot_r;
  slot_entry_t         rd_r;
  logic [SLOTO_W-1:0]  res_slot_r;
  logic [COUNT_W-1:0]  res_count_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOTO_W-1:0]  out_slot_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic [SITE_W-1:0]  row;
  logic [ADDR_W-1:0]  addr;
  logic [COUNT_W-1:0] new_cnt;
  slot_entry_t        wr_data;
  logic               wr_en;

  assign row  = cmd.clr_wr ? ld_r[SITE_W-1:0] : idx_r[SITE_W-1:0];
  assign addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(SLOTS_PER_SITE) + ADDR_W'(slot_r));

  assign new_cnt = (rd_r.cls == cls_r) ?
                   ((rd_r.cnt == '1) ? rd_r.cnt : rd_r.cnt + COUNT_W'(1)) :
                   COUNT_W'(1);

  assign wr_en   = cmd.clr_wr | cmd.upd_wr;
  assign wr_data = cmd.clr_wr ? slot_entry_t'('0) : slot_entry_t'{cls: cls_r, cnt: new_cnt};

  always_comb begin
    sts             = '0;
    sts.in_load     = (in_kind == 1'b0);
    sts.in_cls_zero = (in_class_id == '0);
    sts.table_full  = (ld_r == LD_W'(NUM_SITES));
    sts.site_end    = (idx_r == ld_r);
    sts.site_match  = (pcs_r[idx_r[SITE_W-1:0]] == pc_r);
    sts.slot_last   = (slot_r == SLOT_W'(SLOTS_PER_SITE - 1));
    sts.slot_hit    = (rd_r.cls == cls_r);
    sts.slot_empty  = (rd_r.cls == '0);
    sts.out_free    = !out_valid_r || out_ready;
  end

  // storage
  always_ff @(posedge clk) begin
    if (cmd.pc_wr) begin
      pcs_r[ld_r[SITE_W-1:0]] <= in_site_pc;
    end
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_r <= mem[addr];
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pc_r        <= in_site_pc;
      cls_r       <= in_class_id;
      res_slot_r  <= '0;
      res_count_r <= '0;
    end else if (cmd.upd_wr) begin
      res_slot_r  <= SLOTO_W'(slot_r);
      res_count_r <= new_cnt;
    end
    if (cmd.slot_clr) begin
      slot_r <= '0;
    end else if (cmd.slot_inc) begin
      slot_r <= slot_r + SLOT_W'(1);
    end
    if (cmd.site_clr) begin
      idx_r <= '0;
    end else if (cmd.site_inc) begin
      idx_r <= idx_r + LD_W'(1);
    end
    if (cmd.res_load) begin
      out_status_r <= cmd.res_status;
      out_slot_r   <= res_slot_r;
      out_count_r  <= res_count_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ld_inc) begin
        ld_r <= ld_r + LD_W'(1);
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_count  = out_count_r;

endmodule

>>> src/call_site_receiver_cache.sv
// ----------------------------------------------------------------------------
// call_site_receiver_cache
// Profiling table of call sites with per-site receiver class slots.
// ----------------------------------------------------------------------------
// Each transfer on in_ch yields exactly one transfer on out_ch. A load clears
// the slots of the new site one at a time in the single-port slot memory, and
// a full table or a record with class 0 answers without a search. Otherwise
// the sites are searched one at a time from index 0 up to the match (or up to
// the number of loaded sites when missing), and each slot scanned takes a read
// and a check state, since each slot read goes through the registered port.
// A new item is taken once the previous one has reached the output register.
module call_site_receiver_cache (
  input logic       clk,
  input logic       rst_n,
  csrc_in_if.sink   in_ch,
  csrc_out_if.source out_ch
);
  import csrc_pkg::*;

  csrc_cmd_t cmd;
  csrc_sts_t sts;

  csrc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  csrc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_kind     (in_ch.kind),
    .in_site_pc  (in_ch.site_pc),
    .in_class_id (in_ch.class_id),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_status  (out_ch.status),
    .out_slot    (out_ch.slot),
    .out_count   (out_ch.count),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

>>> src/csrc_checker.sv
// ----------------------------------------------------------------------------
// csrc_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module csrc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [csrc_pkg::STATUS_W-1:0] out_status,
  input logic [csrc_pkg::SLOTO_W-1:0]  out_slot,
  input logic [csrc_pkg::COUNT_W-1:0]  out_count
);
  import csrc_pkg::*;

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_count))
    else $error("stalled result changed");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= STATUS_W'(ST_ZERO_CLASS))
    else $error("undefined status code");

  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_W'(ST_HIT) && out_status != STATUS_W'(ST_INSERTED)
    |-> out_slot == '0 && out_count == '0)
    else $error("slot or count set on a non-update result");

  a_ins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_W'(ST_INSERTED) |-> out_count == COUNT_W'(1))
    else $error("insert without count of one");

endmodule

bind call_site_receiver_cache csrc_checker u_csrc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_slot   (out_ch.slot),
  .out_count  (out_ch.count)
);

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the call site receiver cache. Directed rows cover
// all status codes but table full, extreme values, duplicate sites and a
// megamorphic site; random traffic follows in three flow-control phases.
// Results are compared in order with typed rows or an in-bench profile table.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import csrc_pkg::*;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_RECORD = 1'b1;
  localparam int   RAND_ITEMS  = 317;
  localparam int   DRAIN_CYC   = 40;

  typedef struct packed {
    status_t              status;
    logic [SLOTO_W-1:0]   slot;
    logic [COUNT_W-1:0]   count;
  } result_t;

  typedef struct {
    logic                kind;
    logic [PC_W-1:0]     pc;
    logic [CLASS_W-1:0]  cls;
    bit                  typed;
    result_t             want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  csrc_in_if  in_ch ();
  csrc_out_if out_ch ();

  call_site_receiver_cache i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // profile table as seen by the bench
  logic [PC_W-1:0]    site_pc_tbl [NUM_SITES];
  int                 n_sites = 0;
  logic [CLASS_W-1:0] cls_tbl [TOTAL_SLOTS] = '{default: '0};
  logic [COUNT_W-1:0] cnt_tbl [TOTAL_SLOTS] = '{default: '0};

  result_t pending_profile_results [$];
  int      fail_cnt       = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic result_t predict_profile(logic kind, logic [PC_W-1:0] pc,
                                              logic [CLASS_W-1:0] cls);
    result_t r;
    int      site;
    int      k;
    r.status = ST_LOADED;
    r.slot   = '0;
    r.count  = '0;
    site     = -1;
    if (kind == KIND_LOAD) begin
      if (n_sites >= NUM_SITES) begin
        r.status = ST_TABLE_FULL;
      end else begin
        site_pc_tbl[n_sites] = pc;
        for (int s = 0; s < SLOTS_PER_SITE; s++) begin
          cls_tbl[n_sites*SLOTS_PER_SITE + s] = '0;
          cnt_tbl[n_sites*SLOTS_PER_SITE + s] = '0;
        end
        n_sites++;
      end
      return r;
    end
    if (cls == '0) begin
      r.status = ST_ZERO_CLASS;
      return r;
    end
    for (int i = 0; i < n_sites; i++) begin
      if (site < 0 && site_pc_tbl[i] == pc) site = i;
    end
    if (site < 0) begin
      r.status = ST_MISSING;
      return r;
    end
    r.status = ST_MEGA;
    for (int s = 0; s < SLOTS_PER_SITE; s++) begin
      k = site*SLOTS_PER_SITE + s;
      if (cls_tbl[k] == cls) begin
        if (cnt_tbl[k] != '1) cnt_tbl[k]++;
        r.status = ST_HIT;
        r.slot   = SLOTO_W'(s);
        r.count  = cnt_tbl[k];
        return r;
      end
      if (cls_tbl[k] == '0) begin
        cls_tbl[k] = cls;
        cnt_tbl[k] = COUNT_W'(1);
        r.status = ST_INSERTED;
        r.slot   = SLOTO_W'(s);
        r.count  = COUNT_W'(1);
        return r;
      end
    end
    return r;
  endfunction

  function automatic stim_row_t row_typed(logic kind, logic [PC_W-1:0] pc,
                                          logic [CLASS_W-1:0] cls, status_t st,
                                          logic [SLOTO_W-1:0] slot,
                                          logic [COUNT_W-1:0] count);
    stim_row_t row;
    row.kind        = kind;
    row.pc          = pc;
    row.cls         = cls;
    row.typed       = 1'b1;
    row.want.status = st;
    row.want.slot   = slot;
    row.want.count  = count;
    return row;
  endfunction

  function automatic stim_row_t row_calc(logic kind, logic [PC_W-1:0] pc,
                                         logic [CLASS_W-1:0] cls);
    stim_row_t row;
    row.kind  = kind;
    row.pc    = pc;
    row.cls   = cls;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  task automatic send_item(input logic kind, input logic [PC_W-1:0] pc,
                           input logic [CLASS_W-1:0] cls, input bit typed,
                           input result_t typed_res);
    result_t r;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= kind;
    in_ch.site_pc  <= pc;
    in_ch.class_id <= cls;
    do @(posedge clk); while (!in_ch.ready);
    r = predict_profile(kind, pc, cls);
    if (typed) r = typed_res;
    pending_profile_results = {pending_profile_results, r};
  endtask

  // result sink flow control
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_profile_results.size() == 0) begin
        $display("%0t: unexpected result transfer status %0d slot %0d count %h",
                 $realtime, out_ch.status, out_ch.slot, out_ch.count);
        fail_cnt++;
      end else begin
        want = pending_profile_results.pop_front();
        if (out_ch.status !== want.status || out_ch.slot !== want.slot ||
            out_ch.count !== want.count) begin
          $display({"%0t: mismatch expected status %0d slot %0d count %h,",
                    " actual status %0d slot %0d count %h"},
                   $realtime, want.status, want.slot, want.count,
                   out_ch.status, out_ch.slot, out_ch.count);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    stim_row_t          dir_rows [$];
    logic [CLASS_W-1:0] class_pool [6];
    logic               kind;
    logic [PC_W-1:0]    pc;
    logic [CLASS_W-1:0] cls;
    int                 pick;

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.kind     <= KIND_LOAD;
    in_ch.site_pc  <= '0;
    in_ch.class_id <= '0;

    class_pool[0] = '1;
    for (int i = 1; i < 6; i++) class_pool[i] = $urandom | 32'h0000_0100;

    dir_rows = '{
      row_typed(KIND_RECORD, 32'h0000_0000, 32'h0000_0001, ST_MISSING, 3'd0, 32'd0),
      row_typed(KIND_RECORD, 32'hFFFF_FFFF, 32'h0000_0000, ST_ZERO_CLASS, 3'd0, 32'd0),
      row_typed(KIND_LOAD,   32'h0000_0000, 32'h0000_0000, ST_LOADED, 3'd0, 32'd0),
      row_typed(KIND_LOAD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, ST_LOADED, 3'd0, 32'd0),
      row_typed(KIND_LOAD,   32'h0000_0000, 32'h1234_5678, ST_LOADED, 3'd0, 32'd0),
      row_typed(KIND_RECORD, 32'h0000_0000, 32'h0000_0000, ST_ZERO_CLASS, 3'd0, 32'd0),
      row_typed(KIND_RECORD, 32'h0000_0000, 32'hFFFF_FFFF, ST_INSERTED, 3'd0, 32'd1),
      row_calc (KIND_RECORD, 32'h0000_0000, 32'hFFFF_FFFF),
      row_calc (KIND_RECORD, 32'h0000_0000, 32'h0000_0001),
      row_calc (KIND_RECORD, 32'h0000_0000, 32'h0000_0002),
      row_calc (KIND_RECORD, 32'h0000_0000, 32'h0000_0003),
      row_typed(KIND_RECORD, 32'h0000_0000, 32'h0000_0004, ST_MEGA, 3'd0, 32'd0),
      row_calc (KIND_RECORD, 32'h0000_0000, 32'h0000_0003),
      row_typed(KIND_RECORD, 32'h0000_0001, 32'h0000_0001, ST_MISSING, 3'd0, 32'd0),
      row_calc (KIND_RECORD, 32'hFFFF_FFFF, 32'h0000_0003),
      row_calc (KIND_RECORD, 32'hFFFF_FFFF, 32'h0000_0003),
      row_calc (KIND_LOAD,   32'h8000_0001, 32'h0000_0000),
      row_calc (KIND_RECORD, 32'h8000_0001, 32'h8000_0000),
      row_typed(KIND_RECORD, 32'hFFFF_FFFE, 32'h0000_0001, ST_MISSING, 3'd0, 32'd0)
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 23;
          recv_stall_pct = 86;
        end
        1: begin
          send_idle_pct  = 86;
          recv_stall_pct = 23;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase

      if (phase == 0) begin
        foreach (dir_rows[i])
          send_item(dir_rows[i].kind, dir_rows[i].pc, dir_rows[i].cls,
                    dir_rows[i].typed, dir_rows[i].want);
      end

      for (int n = 0; n < RAND_ITEMS; n++) begin
        pick = $urandom_range(99);
        pc   = (n_sites > 0) ? site_pc_tbl[$urandom_range(n_sites-1)] : $urandom;
        if (pick < 12) begin
          kind = KIND_LOAD;
          if ($urandom_range(3) != 0) pc = $urandom;
          cls = $urandom;
        end else if (pick < 18) begin
          kind = KIND_RECORD;
          if ($urandom_range(1) == 0) pc = $urandom;
          cls = '0;
        end else if (pick < 26) begin
          kind = KIND_RECORD;
          pc   = $urandom;
          cls  = $urandom;
        end else begin
          kind = KIND_RECORD;
          cls  = ($urandom_range(4) == 0) ? $urandom : class_pool[$urandom_range(5)];
        end
        send_item(kind, pc, cls, 1'b0, '0);
      end

      // hold off until the block has drained
      in_ch.valid <= 1'b0;
      while (pending_profile_results.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
